// ===== sv/xibe_pkg.sv =====
package xibe_pkg;

   // Default build settings.
   localparam int OPCODE_BYTES_DEFAULT = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Longest instruction: REX, three opcode bytes, ModR/M, disp32, imm64.
   localparam int MAX_CODE_BYTES = 17;
   localparam int IMM_BYTES_MAX = 8;
   localparam int IDX_W = $clog2(MAX_CODE_BYTES);
   localparam int LEN_W = 5;

   // Addressing modes.
   localparam logic [2:0] AM_REG = 3'd0;
   localparam logic [2:0] AM_RM = 3'd1;
   localparam logic [2:0] AM_DEREF = 3'd2;
   localparam logic [2:0] AM_DISP8 = 3'd3;
   localparam logic [2:0] AM_DISP32 = 3'd4;

   // Relocation kinds.
   localparam logic [1:0] RK_DISP = 2'd1;
   localparam logic [1:0] RK_IMM = 2'd2;

   // Fixed byte patterns.
   localparam logic [7:0] REX_BASE = 8'h40;
   localparam logic [1:0] MOD_REG = 2'b11;
   localparam logic [1:0] MOD_DEREF = 2'b00;
   localparam logic [1:0] MOD_DISP8 = 2'b01;
   localparam logic [1:0] MOD_DISP32 = 2'b10;
   localparam logic [2:0] RM_SIB = 3'd4;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SPACE = 2'd1,
      ST_MODE  = 2'd2,
      ST_SIB   = 2'd3
   } status_type;

   // One classified instruction, as it travels from front to back.
   typedef struct packed {
      status_type status;
      logic has_bytes;
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] roff;
      logic [LEN_W-1:0] count;
      logic [MAX_CODE_BYTES-1:0][7:0] code;
   } item_type;

endpackage

// ===== sv/x86_64_instruction_byte_encoder.sv =====
// The first beat of an instruction passes through the queue entry, then the single output
// register of the back end. One result beat per cycle while the receiver pops; an instruction
// gives as many beats as it has bytes (a single beat for an error or empty result).
// The front end takes one instruction per cycle while the two-entry queue has room.
// Reset is synchronous and clears the queue pointers, the beat index and the output valid.
module x86_64_instruction_byte_encoder
   import xibe_pkg::*;
#(
   parameter int MAX_OPCODE_BYTES = OPCODE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [23:0] req_opcode_value,
   input  logic [1:0]  req_opcode_bytes,
   input  logic        req_wide_operand,
   input  logic [3:0]  req_reg_field,
   input  logic [3:0]  req_rm_field,
   input  logic [2:0]  req_address_mode,
   input  logic [31:0] req_displacement,
   input  logic [63:0] req_immediate,
   input  logic [3:0]  req_immediate_bytes,
   input  logic [1:0]  req_relocation_kind,
   input  logic [4:0]  req_space_left,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic [4:0]  rsp_total_length,
   output logic [4:0]  rsp_relocation_offset,
   output logic [1:0]  rsp_status
);

   item_type front_item;
   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   // Classify the incoming instruction and lay out its bytes.
   xibe_front #(
      .MAX_OPCODE_BYTES(MAX_OPCODE_BYTES)
   ) u_front (
      .opcode_value(req_opcode_value),
      .opcode_bytes(req_opcode_bytes),
      .wide_operand(req_wide_operand),
      .reg_field(req_reg_field),
      .rm_field(req_rm_field),
      .address_mode(req_address_mode),
      .displacement(req_displacement),
      .immediate(req_immediate),
      .immediate_bytes(req_immediate_bytes),
      .relocation_kind(req_relocation_kind),
      .space_left(req_space_left),
      .item(front_item)
   );

   // Decoupling queue between front and back.
   xibe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(push),
      .wr_item(front_item),
      .full(full),
      .rd_en(head_pop),
      .rd_valid(head_valid),
      .rd_item(head_item)
   );

   // Stream the bytes out one beat at a time.
   xibe_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_item(head_item),
      .head_pop(head_pop),
      .empty(empty),
      .pop(pop),
      .code_byte(rsp_code_byte),
      .byte_valid(rsp_byte_valid),
      .last_of_run(rsp_last_of_run),
      .total_length(rsp_total_length),
      .relocation_offset(rsp_relocation_offset),
      .status(rsp_status)
   );

   // A beat that carries a byte belongs to a good instruction of nonzero length.
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_byte_valid |-> rsp_status == ST_OK && rsp_total_length != '0)
      else $error("byte beat with error status or zero length");

   // A beat without a byte is always the only beat of its instruction.
   a_nobyte_single: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_byte_valid |-> rsp_last_of_run && rsp_code_byte == 8'h00)
      else $error("byte-less beat is not a single final beat");

   // An error result reports neither length nor relocation.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status != ST_OK |-> rsp_total_length == '0 &&
      rsp_relocation_offset == '0)
      else $error("error beat carries length or relocation");

   // The queue only releases an instruction while it holds one.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue read while empty");

endmodule

// ===== sv/xibe_front.sv =====
module xibe_front
   import xibe_pkg::*;
#(
   parameter int MAX_OPCODE_BYTES = OPCODE_BYTES_DEFAULT
) (
   input  logic [23:0] opcode_value,
   input  logic [1:0]  opcode_bytes,
   input  logic        wide_operand,
   input  logic [3:0]  reg_field,
   input  logic [3:0]  rm_field,
   input  logic [2:0]  address_mode,
   input  logic [31:0] displacement,
   input  logic [63:0] immediate,
   input  logic [3:0]  immediate_bytes,
   input  logic [1:0]  relocation_kind,
   input  logic [4:0]  space_left,
   output item_type    item
);

   logic             mode_bad;
   logic             sib_conflict;
   logic [1:0]       opc_n;
   logic [3:0]       imm_n;
   logic             rex_n;
   logic             modrm_n;
   logic [2:0]       disp_n;
   logic [LEN_W-1:0] b1;
   logic [LEN_W-1:0] b2;
   logic [LEN_W-1:0] b3;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] roff;
   logic [7:0]       rex_byte;
   logic [7:0]       modrm_byte;
   logic [1:0]       mod_bits;
   logic [31:0]      opc_word;
   status_type       status;

   // Mode checks and segment sizes.
   always_comb begin
      mode_bad = address_mode > AM_DISP32;
      sib_conflict = (address_mode == AM_DEREF || address_mode == AM_DISP8 ||
                      address_mode == AM_DISP32) && rm_field[2:0] == RM_SIB;
      if (int'(opcode_bytes) > MAX_OPCODE_BYTES) begin
         opc_n = 2'(MAX_OPCODE_BYTES);
      end else begin
         opc_n = opcode_bytes;
      end
      if (immediate_bytes > 4'(IMM_BYTES_MAX)) begin
         imm_n = 4'(IMM_BYTES_MAX);
      end else begin
         imm_n = immediate_bytes;
      end
      rex_n = wide_operand | reg_field[3] | rm_field[3];
      modrm_n = address_mode != AM_REG;
      case (address_mode)
         AM_DISP8: begin
            disp_n = 3'd1;
            mod_bits = MOD_DISP8;
         end
         AM_DISP32: begin
            disp_n = 3'd4;
            mod_bits = MOD_DISP32;
         end
         AM_RM: begin
            disp_n = 3'd0;
            mod_bits = MOD_REG;
         end
         default: begin
            disp_n = 3'd0;
            mod_bits = MOD_DEREF;
         end
      endcase
   end

   // Segment boundaries, length and relocation offset.
   always_comb begin
      b1 = LEN_W'(rex_n) + LEN_W'(opc_n);
      b2 = b1 + LEN_W'(modrm_n);
      b3 = b2 + LEN_W'(disp_n);
      len = b3 + LEN_W'(imm_n);
      if (relocation_kind == RK_DISP && modrm_n) begin
         roff = b2;
      end else if (relocation_kind == RK_IMM) begin
         roff = b3;
      end else begin
         roff = '0;
      end
      if (mode_bad) begin
         status = ST_MODE;
      end else if (sib_conflict) begin
         status = ST_SIB;
      end else if (len > space_left) begin
         status = ST_SPACE;
      end else begin
         status = ST_OK;
      end
   end

   // Fixed bytes: REX, merged opcode and ModR/M.
   always_comb begin
      rex_byte = REX_BASE | {4'b0000, wide_operand, reg_field[3], 1'b0, rm_field[3]};
      modrm_byte = {mod_bits, reg_field[2:0], rm_field[2:0]};
      opc_word = {8'h00, opcode_value};
      if (address_mode == AM_REG) begin
         opc_word[2:0] = opcode_value[2:0] | rm_field[2:0];
      end
   end

   // Lay out every byte position; each one picks its segment.
   always_comb begin
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] d_opc;
      logic [LEN_W-1:0] d_disp;
      logic [LEN_W-1:0] d_imm;
      item.status = status;
      item.has_bytes = status == ST_OK && len != '0;
      item.length = (status == ST_OK) ? len : '0;
      item.roff = (status == ST_OK) ? roff : '0;
      item.count = item.has_bytes ? len : LEN_W'(1);
      for (int p = 0; p < MAX_CODE_BYTES; p++) begin
         pos = LEN_W'(p);
         d_opc = pos - LEN_W'(rex_n);
         d_disp = pos - b2;
         d_imm = pos - b3;
         if (pos < LEN_W'(rex_n)) begin
            item.code[p] = rex_byte;
         end else if (pos < b1) begin
            item.code[p] = opc_word[{d_opc[1:0], 3'b000} +: 8];
         end else if (pos < b2) begin
            item.code[p] = modrm_byte;
         end else if (pos < b3) begin
            item.code[p] = displacement[{d_disp[1:0], 3'b000} +: 8];
         end else begin
            item.code[p] = immediate[{d_imm[2:0], 3'b000} +: 8];
         end
      end
   end

endmodule

// ===== sv/xibe_queue.sv =====
module xibe_queue
   import xibe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_item,
   output logic     full,
   input  logic     rd_en,
   output logic     rd_valid,
   output item_type rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign full = count_ff == CNT_W'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_item = entry_ff[rd_ptr_ff];
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && rd_valid;

   // Pointer and fill count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== sv/xibe_back.sv =====
module xibe_back
   import xibe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  item_type         head_item,
   output logic             head_pop,
   output logic             empty,
   input  logic             pop,
   output logic [7:0]       code_byte,
   output logic             byte_valid,
   output logic             last_of_run,
   output logic [LEN_W-1:0] total_length,
   output logic [LEN_W-1:0] relocation_offset,
   output logic [1:0]       status
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       byte_ff;
   logic             byte_valid_ff;
   logic             last_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] roff_ff;
   status_type       status_ff;
   logic             load;
   logic             is_last;

   // A new beat enters the output register when it is free or being drained.
   assign load = head_valid && (!out_valid_ff || pop);
   assign is_last = LEN_W'(idx_ff) + 1'b1 == head_item.count;
   assign head_pop = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in = is_last ? '0 : idx_ff + 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output beat payload.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_item.has_bytes ? head_item.code[idx_ff] : 8'h00;
         byte_valid_ff <= head_item.has_bytes;
         last_ff <= is_last;
         len_ff <= head_item.length;
         roff_ff <= head_item.roff;
         status_ff <= head_item.status;
      end
   end

   assign empty = !out_valid_ff;
   assign code_byte = byte_ff;
   assign byte_valid = byte_valid_ff;
   assign last_of_run = last_ff;
   assign total_length = len_ff;
   assign relocation_offset = roff_ff;
   assign status = status_ff;

endmodule

// ===== bench/x86_64_instruction_byte_encoder_tb.sv =====
module x86_64_instruction_byte_encoder_tb;
   import xibe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPC_LIMIT = OPCODE_BYTES_DEFAULT;
   localparam int RANDOM_INSTRS = 460;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 250000;

   // No relocation requested.
   localparam logic [1:0] RK_NONE = 2'd0;

   // Idling phases of the run.
   localparam logic [1:0] PHASE_SLOW_RECV = 2'd0;
   localparam logic [1:0] PHASE_SLOW_SEND = 2'd1;
   localparam logic [1:0] PHASE_FREE = 2'd2;

   // One instruction description as it is offered on the request side.
   typedef struct packed {
      logic [23:0] opcode_value;
      logic [1:0]  opcode_bytes;
      logic        wide_operand;
      logic [3:0]  reg_field;
      logic [3:0]  rm_field;
      logic [2:0]  address_mode;
      logic [31:0] displacement;
      logic [63:0] immediate;
      logic [3:0]  immediate_bytes;
      logic [1:0]  relocation_kind;
      logic [4:0]  space_left;
   } instr_type;

   // One result beat: a code byte or a status-only beat.
   typedef struct packed {
      logic [7:0] code_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic [4:0] total_length;
      logic [4:0] relocation_offset;
      status_type status;
   } code_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [23:0] req_opcode_value = '0;
   logic [1:0]  req_opcode_bytes = '0;
   logic        req_wide_operand = 1'b0;
   logic [3:0]  req_reg_field = '0;
   logic [3:0]  req_rm_field = '0;
   logic [2:0]  req_address_mode = '0;
   logic [31:0] req_displacement = '0;
   logic [63:0] req_immediate = '0;
   logic [3:0]  req_immediate_bytes = '0;
   logic [1:0]  req_relocation_kind = '0;
   logic [4:0]  req_space_left = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_code_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_run;
   logic [4:0]  rsp_total_length;
   logic [4:0]  rsp_relocation_offset;
   logic [1:0]  rsp_status;

   instr_type     pending_instrs[$];
   code_beat_type expected_beats[$];
   int            total_instrs = 0;
   int            accepted_instrs = 0;
   int            mismatch_count = 0;
   int            checked_beats = 0;
   int            n_code_bytes = 0;
   int            n_error_results = 0;
   int            n_empty_results = 0;
   int            cycle_count = 0;
   logic [1:0]    idle_phase = PHASE_SLOW_RECV;

   x86_64_instruction_byte_encoder u_top (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_opcode_value      (req_opcode_value),
      .req_opcode_bytes      (req_opcode_bytes),
      .req_wide_operand      (req_wide_operand),
      .req_reg_field         (req_reg_field),
      .req_rm_field          (req_rm_field),
      .req_address_mode      (req_address_mode),
      .req_displacement      (req_displacement),
      .req_immediate         (req_immediate),
      .req_immediate_bytes   (req_immediate_bytes),
      .req_relocation_kind   (req_relocation_kind),
      .req_space_left        (req_space_left),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_code_byte         (rsp_code_byte),
      .rsp_byte_valid        (rsp_byte_valid),
      .rsp_last_of_run       (rsp_last_of_run),
      .rsp_total_length      (rsp_total_length),
      .rsp_relocation_offset (rsp_relocation_offset),
      .rsp_status            (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Encodes one instruction and appends the beats it must produce.
   function automatic void encode_instr(input instr_type ins);
      logic [7:0]    code [MAX_CODE_BYTES];
      logic [4:0]    len;
      logic [4:0]    reloc_at;
      logic [23:0]   opc;
      logic [1:0]    modrm_mod;
      int            n_opc;
      int            n_imm;
      int            n_disp;
      int            i;
      status_type    err;
      code_beat_type beat;

      len = '0;
      reloc_at = '0;
      err = ST_OK;
      n_disp = 0;
      modrm_mod = MOD_DEREF;

      // Mode is checked first, then the base register that would need a SIB byte.
      if (ins.address_mode > AM_DISP32) begin
         err = ST_MODE;
      end else if (ins.address_mode >= AM_DEREF && ins.rm_field[2:0] == RM_SIB) begin
         err = ST_SIB;
      end

      if (err == ST_OK) begin
         n_opc = (ins.opcode_bytes > OPC_LIMIT) ? OPC_LIMIT : int'(ins.opcode_bytes);
         n_imm = (ins.immediate_bytes > IMM_BYTES_MAX) ? IMM_BYTES_MAX
                                                       : int'(ins.immediate_bytes);

         // REX is needed for a 64-bit operand or any extended register.
         if (ins.wide_operand || ins.reg_field[3] || ins.rm_field[3]) begin
            code[len] = REX_BASE | {4'h0, ins.wide_operand, ins.reg_field[3], 1'b0,
                                    ins.rm_field[3]};
            len++;
         end

         // Opcode bytes go out low byte first; the register may ride in the first one.
         opc = ins.opcode_value;
         if (ins.address_mode == AM_REG) begin
            opc[2:0] = opc[2:0] | ins.rm_field[2:0];
         end
         for (i = 0; i < n_opc; i++) begin
            code[len] = opc[8*i +: 8];
            len++;
         end

         // ModR/M and the displacement that its mod field asks for.
         if (ins.address_mode != AM_REG) begin
            case (ins.address_mode)
               AM_RM: begin
                  modrm_mod = MOD_REG;
               end
               AM_DISP8: begin
                  modrm_mod = MOD_DISP8;
                  n_disp = 1;
               end
               AM_DISP32: begin
                  modrm_mod = MOD_DISP32;
                  n_disp = 4;
               end
               default: begin
                  modrm_mod = MOD_DEREF;
               end
            endcase
            code[len] = {modrm_mod, ins.reg_field[2:0], ins.rm_field[2:0]};
            len++;
            if (ins.relocation_kind == RK_DISP) begin
               reloc_at = len;
            end
            for (i = 0; i < n_disp; i++) begin
               code[len] = ins.displacement[8*i +: 8];
               len++;
            end
         end

         if (ins.relocation_kind == RK_IMM) begin
            reloc_at = len;
         end
         for (i = 0; i < n_imm; i++) begin
            code[len] = ins.immediate[8*i +: 8];
            len++;
         end

         // The whole length must fit before anything is emitted.
         if (len > ins.space_left) begin
            err = ST_SPACE;
         end
      end

      if (err != ST_OK || len == 0) begin
         beat.code_byte = '0;
         beat.byte_valid = 1'b0;
         beat.last_of_run = 1'b1;
         beat.total_length = '0;
         beat.relocation_offset = (err == ST_OK) ? reloc_at : 5'd0;
         beat.status = err;
         expected_beats.push_back(beat);
         if (err == ST_OK) begin
            n_empty_results++;
         end else begin
            n_error_results++;
         end
      end else begin
         for (i = 0; i < int'(len); i++) begin
            beat.code_byte = code[i];
            beat.byte_valid = 1'b1;
            beat.last_of_run = (i + 1 == int'(len));
            beat.total_length = len;
            beat.relocation_offset = reloc_at;
            beat.status = ST_OK;
            expected_beats.push_back(beat);
         end
         n_code_bytes += int'(len);
      end
   endfunction

   task automatic queue_instr(input logic [23:0] opc, input logic [1:0] n_opc,
                              input logic w, input logic [3:0] reg_no,
                              input logic [3:0] rm_no, input logic [2:0] mode,
                              input logic [31:0] disp, input logic [63:0] imm,
                              input logic [3:0] n_imm, input logic [1:0] rkind,
                              input logic [4:0] space);
      instr_type ins;
      ins.opcode_value = opc;
      ins.opcode_bytes = n_opc;
      ins.wide_operand = w;
      ins.reg_field = reg_no;
      ins.rm_field = rm_no;
      ins.address_mode = mode;
      ins.displacement = disp;
      ins.immediate = imm;
      ins.immediate_bytes = n_imm;
      ins.relocation_kind = rkind;
      ins.space_left = space;
      pending_instrs.push_back(ins);
   endtask

   function automatic int send_idle_pct(input logic [1:0] phase);
      case (phase)
         PHASE_SLOW_RECV: return 38;
         PHASE_SLOW_SEND: return 71;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct(input logic [1:0] phase);
      case (phase)
         PHASE_SLOW_RECV: return 71;
         PHASE_SLOW_SEND: return 38;
         default: return 0;
      endcase
   endfunction

   // Request side: predict each accepted beat, then offer the next instruction.
   always @(posedge clock) begin : driver
      instr_type taken;
      instr_type next_ins;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            taken = pending_instrs.pop_front();
            encode_instr(taken);
            accepted_instrs++;
         end
         idle_phase <= (accepted_instrs * 3 < total_instrs) ? PHASE_SLOW_RECV :
                       (accepted_instrs * 3 < total_instrs * 2) ? PHASE_SLOW_SEND :
                       PHASE_FREE;
         if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct(idle_phase)) begin
            next_ins = pending_instrs[0];
            req_opcode_value <= next_ins.opcode_value;
            req_opcode_bytes <= next_ins.opcode_bytes;
            req_wide_operand <= next_ins.wide_operand;
            req_reg_field <= next_ins.reg_field;
            req_rm_field <= next_ins.rm_field;
            req_address_mode <= next_ins.address_mode;
            req_displacement <= next_ins.displacement;
            req_immediate <= next_ins.immediate;
            req_immediate_bytes <= next_ins.immediate_bytes;
            req_relocation_kind <= next_ins.relocation_kind;
            req_space_left <= next_ins.space_left;
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Result side: every popped beat is checked against the oldest prediction.
   always @(posedge clock) begin : monitor
      code_beat_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: code_byte %0h status %0d",
                      rsp_code_byte, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               checked_beats++;
               if (rsp_code_byte !== want.code_byte) begin
                  $error("rsp_code_byte: expected %0h, got %0h", want.code_byte, rsp_code_byte);
                  mismatch_count++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("rsp_byte_valid: expected %0d, got %0d", want.byte_valid,
                         rsp_byte_valid);
                  mismatch_count++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("rsp_last_of_run: expected %0d, got %0d", want.last_of_run,
                         rsp_last_of_run);
                  mismatch_count++;
               end
               if (rsp_total_length !== want.total_length) begin
                  $error("rsp_total_length: expected %0d, got %0d", want.total_length,
                         rsp_total_length);
                  mismatch_count++;
               end
               if (rsp_relocation_offset !== want.relocation_offset) begin
                  $error("rsp_relocation_offset: expected %0d, got %0d",
                         want.relocation_offset, rsp_relocation_offset);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct(idle_phase));
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d instructions still pending.",
               cycle_count, pending_instrs.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      instr_type ins;
      int        sel;
      int        n;

      // Directed cases: the REX bits, every mode, errors and their precedence,
      // buffer boundaries, saturation, relocation placement and field extremes.
      queue_instr(24'h0000b8, 2'd1, 1'b1, 4'd0, 4'd0, AM_REG, 32'h0,
                  64'h7fff_ffff_ffff_ffff, 4'd8, RK_IMM, 5'd31);
      queue_instr(24'h0000b8, 2'd1, 1'b0, 4'd0, 4'd15, AM_REG, 32'h0,
                  64'h8000_0000_0000_0000, 4'd8, RK_NONE, 5'd31);
      queue_instr(24'h000050, 2'd1, 1'b0, 4'd0, 4'd7, AM_REG, 32'h0, 64'h0, 4'd0,
                  RK_DISP, 5'd31);
      queue_instr(24'h000089, 2'd1, 1'b1, 4'd15, 4'd8, AM_RM, 32'h0, 64'h0, 4'd0,
                  RK_NONE, 5'd31);
      queue_instr(24'h00008b, 2'd1, 1'b0, 4'd3, 4'd5, AM_DEREF, 32'hdead_beef, 64'h0,
                  4'd0, RK_DISP, 5'd31);
      queue_instr(24'h00008b, 2'd1, 1'b1, 4'd9, 4'd1, AM_DISP8, 32'hffff_ff80, 64'h0,
                  4'd0, RK_DISP, 5'd31);
      // Longest instruction, with room to spare, an exact fit, and one byte short.
      queue_instr(24'hff_ffff, 2'd3, 1'b1, 4'd15, 4'd13, AM_DISP32, 32'h8000_0000,
                  64'hffff_ffff_ffff_ffff, 4'd8, RK_IMM, 5'd31);
      queue_instr(24'h0f_38f0, 2'd3, 1'b1, 4'd14, 4'd11, AM_DISP32, 32'h7fff_ffff,
                  64'h0123_4567_89ab_cdef, 4'd8, RK_DISP, 5'd17);
      queue_instr(24'h0f_38f0, 2'd3, 1'b1, 4'd14, 4'd11, AM_DISP32, 32'h7fff_ffff,
                  64'h0123_4567_89ab_cdef, 4'd8, RK_DISP, 5'd16);
      // Invalid modes win over a conflicting base and a zero-sized buffer.
      queue_instr(24'h000001, 2'd1, 1'b0, 4'd0, 4'd4, 3'd5, 32'h0, 64'h0, 4'd0, RK_NONE,
                  5'd0);
      queue_instr(24'h000001, 2'd1, 1'b1, 4'd2, 4'd3, 3'd6, 32'h0, 64'h0, 4'd0, RK_NONE,
                  5'd31);
      queue_instr(24'h000001, 2'd1, 1'b0, 4'd2, 4'd3, 3'd7, 32'h0, 64'h0, 4'd0, RK_NONE,
                  5'd31);
      // A dereference through RSP or R12 beats a buffer that is too small.
      queue_instr(24'h00008b, 2'd1, 1'b0, 4'd0, 4'd4, AM_DEREF, 32'h0, 64'h0, 4'd0,
                  RK_NONE, 5'd0);
      queue_instr(24'h00008b, 2'd1, 1'b1, 4'd0, 4'd12, AM_DISP8, 32'h12, 64'h0, 4'd0,
                  RK_NONE, 5'd31);
      queue_instr(24'h00008b, 2'd1, 1'b0, 4'd7, 4'd4, AM_DISP32, 32'h1234, 64'h0, 4'd0,
                  RK_NONE, 5'd31);
      // RSP and R12 are fine as a register operand or an in-opcode register.
      queue_instr(24'h000089, 2'd1, 1'b0, 4'd1, 4'd4, AM_RM, 32'h0, 64'h0, 4'd0, RK_NONE,
                  5'd31);
      queue_instr(24'h000058, 2'd1, 1'b0, 4'd0, 4'd12, AM_REG, 32'h0, 64'h0, 4'd0,
                  RK_NONE, 5'd2);
      // Empty instructions give a lone status beat.
      queue_instr(24'h000000, 2'd0, 1'b0, 4'd0, 4'd0, AM_REG, 32'h0, 64'h0, 4'd0,
                  RK_IMM, 5'd0);
      queue_instr(24'hab_cdef, 2'd0, 1'b0, 4'd0, 4'd7, AM_REG, 32'hffff_ffff,
                  64'hffff_ffff_ffff_ffff, 4'd0, 2'd3, 5'd31);
      // Immediate counts above eight saturate.
      queue_instr(24'h0000c7, 2'd1, 1'b1, 4'd0, 4'd0, AM_RM, 32'h0,
                  64'hfedc_ba98_7654_3210, 4'd15, RK_IMM, 5'd31);
      queue_instr(24'h0000c7, 2'd1, 1'b0, 4'd0, 4'd6, AM_DISP8, 32'h0000_007f,
                  64'h1111_2222_3333_4444, 4'd9, RK_IMM, 5'd31);
      queue_instr(24'h000000, 2'd0, 1'b0, 4'd5, 4'd2, AM_RM, 32'h0, 64'h0, 4'd0, RK_NONE,
                  5'd1);
      queue_instr(24'h000090, 2'd1, 1'b0, 4'd0, 4'd0, AM_REG, 32'h0, 64'h0, 4'd0, RK_NONE,
                  5'd0);
      queue_instr(24'h000081, 2'd1, 1'b0, 4'd0, 4'd3, AM_DISP32, 32'h5555_aaaa,
                  64'h0000_0000_8000_0001, 4'd4, 2'd3, 5'd31);
      queue_instr(24'h00af0f, 2'd2, 1'b0, 4'd8, 4'd0, AM_RM, 32'h0,
                  64'h0000_0000_ffff_ffff, 4'd4, RK_IMM, 5'd31);

      // Random part: mostly well-formed encodings that fit, some noise and errors.
      for (n = 0; n < RANDOM_INSTRS; n++) begin
         sel = $urandom_range(99);
         ins.opcode_value = {8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255))};
         ins.opcode_bytes = 2'($urandom_range(3));
         ins.wide_operand = 1'($urandom_range(1));
         ins.reg_field = 4'($urandom_range(15));
         ins.rm_field = 4'($urandom_range(15));
         ins.address_mode = (sel < 8) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
         if (sel >= 8 && sel < 92 && ins.address_mode >= AM_DEREF &&
             ins.rm_field[2:0] == RM_SIB) begin
            ins.rm_field[0] = 1'b1;
         end
         ins.displacement = $urandom;
         ins.immediate = {$urandom, $urandom};
         case ($urandom_range(5))
            0: ins.immediate_bytes = 4'd0;
            1: ins.immediate_bytes = 4'd1;
            2: ins.immediate_bytes = 4'd4;
            3: ins.immediate_bytes = 4'd8;
            default: ins.immediate_bytes = 4'($urandom_range(15));
         endcase
         ins.relocation_kind = 2'($urandom_range(3));
         ins.space_left = (sel >= 85) ? 5'($urandom_range(31)) : 5'(31 - $urandom_range(14));
         pending_instrs.push_back(ins);
      end
      total_instrs = pending_instrs.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d instructions into %0d checked beats: %0d code bytes,",
               accepted_instrs, checked_beats, n_code_bytes);
      $display("%0d error results and %0d empty results, under three idling patterns.",
               n_error_results, n_empty_results);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
